FILE: rtl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package dq_pkg;

    typedef logic signed [31:0] t_word;

    // Operation codes carried by the op field.
    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    // Status codes carried by the status field.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Value returned by a pop that finds the queue empty.
    localparam t_word EMPTY_WORD = -32'sd1;

    // What one copy of the store does in a cell during a cycle.
    typedef enum logic [1:0] {
        MV_HOLD = 2'd0,
        MV_SHR  = 2'd1,
        MV_SHL  = 2'd2,
        MV_APP  = 2'd3
    } t_move;

    // Each cell keeps entry i of two copies: the forward copy runs front to back,
    // the reverse copy runs back to front.
    typedef struct packed {
        t_word fwd;
        t_word rev;
    } t_pair;

    typedef struct packed {
        t_move fwd_mv;
        t_move rev_mv;
    } t_cell_ctl;

endpackage

FILE: rtl/dq_if.sv
// Valid/ready channel interfaces for the double-ended queue.
// Depends on dq_pkg for the word type.
interface dq_in_if;
    logic            valid;
    logic            ready;
    logic [1:0]      op;
    dq_pkg::t_word   data_in;

    modport source (output valid, output op, output data_in, input ready);
    modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface dq_out_if;
    logic            valid;
    logic            ready;
    dq_pkg::t_word   data_out;
    logic [1:0]      status;
    logic            is_empty;

    modport source (output valid, output data_out, output status, output is_empty,
                    input ready);
    modport sink   (input valid, input data_out, input status, input is_empty,
                    output ready);
endinterface

FILE: rtl/dq_cell.sv
// One storage cell of the queue chain: entry INDEX of the forward and reverse copies.
// Depends on dq_pkg; instantiated in a row by double_ended_queue.
module dq_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic              i_clk,
    input  dq_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]     i_count,
    input  dq_pkg::t_word     i_word,
    input  dq_pkg::t_pair     i_lo,
    input  dq_pkg::t_pair     i_hi,
    output dq_pkg::t_pair     o_pair
);

    dq_pkg::t_pair r_pair;
    dq_pkg::t_pair n_pair;
    logic          w_at_tail;

    // An append lands in the first free cell, which is the one whose index equals the count.
    assign w_at_tail = (i_count == CW'(INDEX));

    always_comb begin
        n_pair = r_pair;
        case (i_ctl.fwd_mv)
            dq_pkg::MV_SHR: n_pair.fwd = i_lo.fwd;
            dq_pkg::MV_SHL: n_pair.fwd = i_hi.fwd;
            dq_pkg::MV_APP: begin
                if (w_at_tail) begin
                    n_pair.fwd = i_word;
                end
            end
            default: n_pair.fwd = r_pair.fwd;
        endcase
        case (i_ctl.rev_mv)
            dq_pkg::MV_SHR: n_pair.rev = i_lo.rev;
            dq_pkg::MV_SHL: n_pair.rev = i_hi.rev;
            dq_pkg::MV_APP: begin
                if (w_at_tail) begin
                    n_pair.rev = i_word;
                end
            end
            default: n_pair.rev = r_pair.rev;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pair <= n_pair;
    end

    assign o_pair = r_pair;

endmodule

FILE: rtl/dq_ctrl.sv
// Control for the double-ended queue: entry count, cell moves and the result register.
// Depends on dq_pkg and the channel interfaces in dq_if.sv.
module dq_ctrl #(
    parameter int CAPACITY = 16,
    parameter int CW       = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dq_in_if.sink             i_in,
    dq_out_if.source          o_out,
    input  dq_pkg::t_pair     i_head,
    output dq_pkg::t_cell_ctl o_ctl,
    output logic [CW-1:0]     o_count
);

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    dq_pkg::t_word     r_data_out;
    dq_pkg::t_word     n_data_out;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    logic              r_is_empty;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    dq_pkg::t_cell_ctl w_ctl;

    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign w_accept = i_in.valid && i_in.ready;

    always_comb begin
        w_ctl      = '{fwd_mv: dq_pkg::MV_HOLD, rev_mv: dq_pkg::MV_HOLD};
        n_count    = r_count;
        n_data_out = '0;
        n_status   = dq_pkg::ST_DONE;
        case (i_in.op)
            dq_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = dq_pkg::ST_FULL;
                end else begin
                    w_ctl   = '{fwd_mv: dq_pkg::MV_SHR, rev_mv: dq_pkg::MV_APP};
                    n_count = r_count + CW'(1);
                end
            end
            dq_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = dq_pkg::ST_FULL;
                end else begin
                    w_ctl   = '{fwd_mv: dq_pkg::MV_APP, rev_mv: dq_pkg::MV_SHR};
                    n_count = r_count + CW'(1);
                end
            end
            dq_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    n_data_out = dq_pkg::EMPTY_WORD;
                    n_status   = dq_pkg::ST_EMPTY;
                end else begin
                    // The reverse copy loses its deepest entry just by the count dropping.
                    n_data_out = i_head.fwd;
                    w_ctl      = '{fwd_mv: dq_pkg::MV_SHL, rev_mv: dq_pkg::MV_HOLD};
                    n_count    = r_count - CW'(1);
                end
            end
            default: begin
                if (w_empty) begin
                    n_data_out = dq_pkg::EMPTY_WORD;
                    n_status   = dq_pkg::ST_EMPTY;
                end else begin
                    n_data_out = i_head.rev;
                    w_ctl      = '{fwd_mv: dq_pkg::MV_HOLD, rev_mv: dq_pkg::MV_SHL};
                    n_count    = r_count - CW'(1);
                end
            end
        endcase
    end

    assign o_ctl   = w_accept ? w_ctl
                   : dq_pkg::t_cell_ctl'{fwd_mv: dq_pkg::MV_HOLD, rev_mv: dq_pkg::MV_HOLD};
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_out <= n_data_out;
            r_status   <= n_status;
            r_is_empty <= (n_count == '0);
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_data_out;
    assign o_out.status   = r_status;
    assign o_out.is_empty = r_is_empty;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_pop_front_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.op == dq_pkg::OP_POP_FRONT && !w_empty)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop from front did not remove one entry");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_is_empty == (r_count == '0)))
        else $error("empty flag of pending word disagrees with count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == dq_pkg::ST_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("full status reported while queue had room");
`endif

endmodule

FILE: rtl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words, built as a row of CAPACITY cells.
// A result word is registered and becomes valid in the cycle after its operation word is accepted.
// Throughput: one operation per cycle unless a pending result is not taken; the cells shift or load in that same cycle.
// Reset clears the entry count and the result valid; cell contents are left as they are.
// Depends on dq_pkg, dq_if, dq_cell and dq_ctrl.
module double_ended_queue #(
    parameter int CAPACITY = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_in_if.sink    i_in,
    dq_out_if.source o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    dq_pkg::t_pair     w_pair [CAPACITY];
    dq_pkg::t_cell_ctl w_ctl;
    logic [CW-1:0]     w_count;

    dq_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_head  (w_pair[0]),
        .o_ctl   (w_ctl),
        .o_count (w_count)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        dq_pkg::t_pair w_lo;
        dq_pkg::t_pair w_hi;

        // A right shift feeds the incoming word into the first cell of either copy.
        if (g == 0) begin : g_first
            assign w_lo = '{fwd: i_in.data_in, rev: i_in.data_in};
        end else begin : g_mid_lo
            assign w_lo = w_pair[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_hi = w_pair[g];
        end else begin : g_mid_hi
            assign w_hi = w_pair[g+1];
        end

        dq_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (w_count),
            .i_word  (i_in.data_in),
            .i_lo    (w_lo),
            .i_hi    (w_hi),
            .o_pair  (w_pair[g])
        );
    end

endmodule
